// ----- hw/rtl/accumulator_machine_execute_top_macros.svh -----
// assertion macros shared by the checker of the accumulator machine
// no dependencies
`ifndef ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AME_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ame check failed");

// antecedent implies consequent in the next cycle
`define AME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ame check failed");

`endif

// ----- hw/rtl/ame_pkg.sv -----
// shared types and codes of the accumulator machine execute block
// no dependencies
package ame_pkg;

    typedef enum logic [5:0] {
        OP_ADD   = 6'd0,  OP_SUB   = 6'd1,  OP_MUL   = 6'd2,  OP_DIV   = 6'd3,
        OP_MOD   = 6'd4,  OP_OR    = 6'd5,  OP_AND   = 6'd6,  OP_XOR   = 6'd7,
        OP_SHL   = 6'd8,  OP_SHR   = 6'd9,  OP_GET   = 6'd10, OP_PUT   = 6'd11,
        OP_GETI  = 6'd12, OP_PUTI  = 6'd13, OP_DECM  = 6'd14, OP_INCM  = 6'd15,
        OP_AT    = 6'd16, OP_COPY  = 6'd17, OP_INC   = 6'd18, OP_DEC   = 6'd19,
        OP_IMM   = 6'd20, OP_FLIP  = 6'd21, OP_SWAP  = 6'd22, OP_TOB   = 6'd23,
        OP_TOT   = 6'd24, OP_TOR   = 6'd25, OP_FROMB = 6'd26, OP_FROMT = 6'd27,
        OP_FROMR = 6'd28, OP_MDM   = 6'd29, OP_LSA   = 6'd30, OP_LSE   = 6'd31,
        OP_NOP   = 6'd32, OP_HALT  = 6'd33, OP_JMPA  = 6'd34, OP_JMPB  = 6'd35,
        OP_JMPE  = 6'd36, OP_JMPN  = 6'd37, OP_JMPS  = 6'd38, OP_JMPU  = 6'd39,
        OP_JUMP  = 6'd40, OP_RPT   = 6'd41, OP_GO    = 6'd42, OP_RS    = 6'd43
    } t_mode;

    typedef enum logic [2:0] {
        P_NONE, P_CLEAR, P_LATCH, P_EXEC, P_MEM1, P_MEM2, P_DIV, P_FINISH
    } t_phase;

    typedef enum logic [1:0] {
        CL_SIMPLE, CL_MEM1, CL_MEM2, CL_DIV
    } t_class;

    typedef struct packed {
        t_phase phase;
    } t_cmd;

    typedef struct packed {
        logic   clear_last;
        t_class cls;
        logic   div_last;
        logic   out_full;
    } t_stat;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

endpackage

// ----- hw/rtl/ame_ctrl.sv -----
// controller state machine of the accumulator machine
// depends on ame_pkg
module ame_ctrl import ame_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_ready
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_MEM1, S_MEM2, S_DIV, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        n_state   = r_state;
        o_cmd.phase = P_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.phase = P_CLEAR;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.phase = P_LATCH;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.phase = P_EXEC;
                case (i_stat.cls)
                    CL_MEM1, CL_MEM2: n_state = S_MEM1;
                    CL_DIV:           n_state = S_DIV;
                    default:          n_state = S_DONE;
                endcase
            end
            S_MEM1: begin
                o_cmd.phase = P_MEM1;
                n_state = (i_stat.cls == CL_MEM2) ? S_MEM2 : S_DONE;
            end
            S_MEM2: begin
                o_cmd.phase = P_MEM2;
                n_state = S_DONE;
            end
            S_DIV: begin
                o_cmd.phase = P_DIV;
                if (i_stat.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                // wait here while the previous result is still held
                if (!i_stat.out_full) begin
                    o_cmd.phase = P_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_ready = r_ready;

endmodule

// ----- hw/rtl/ame_dpath.sv -----
// datapath: registers, data memory, link stack, divider and result register
// depends on ame_pkg
module ame_dpath import ame_pkg::*; #(
    parameter int DATA_WORDS     = 65536,
    parameter int LINK_DEPTH     = 256,
    parameter int PROG_ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [5:0]  i_mode,
    input  logic [30:0] i_immediate,
    input  logic [15:0] i_return_address,
    input  logic        i_ready,
    output logic        o_valid,
    output logic        o_branch_taken,
    output logic [15:0] o_resume_address,
    output logic        o_halted,
    output logic [7:0]  o_exit_code,
    output logic [31:0] o_accumulator_value
);

    localparam int AW = $clog2(DATA_WORDS);
    localparam int LB = $clog2(LINK_DEPTH);
    localparam logic [15:0] RET_MASK = (PROG_ADDR_BITS >= 16) ? 16'hffff :
        16'((32'd1 << PROG_ADDR_BITS) - 32'd1);
    localparam logic [LB-1:0] LINK_TOP = LB'(LINK_DEPTH - 1);

    // architectural state
    logic [31:0] r_a, n_a, r_b, n_b, r_t, n_t, r_r, n_r;
    logic [LB-1:0] r_lcnt, n_lcnt;
    logic        r_halt, n_halt;
    // current request
    t_mode       r_mode;
    logic [30:0] r_imm;
    logic [15:0] r_ret;
    logic        r_taken, n_taken;
    logic [15:0] r_resume, n_resume;
    // clearing sweep and divider
    logic [AW-1:0] r_clr;
    logic [31:0] r_quo, n_quo, r_rem, n_rem;
    logic [4:0]  r_dcnt, n_dcnt;
    logic [32:0] div_trial;
    // memories
    logic [31:0] mem [DATA_WORDS];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wdata;
    logic [15:0] stk [LINK_DEPTH];
    logic [15:0] r_stk_q;
    logic        stk_we;
    logic [LB-1:0] push_idx;
    // result register
    logic        r_ovalid;
    logic        r_otaken, r_ohalt;
    logic [15:0] r_oresume;
    logic [31:0] r_oacc;

    logic [AW-1:0] addr_b, addr_d, addr_copy;
    logic [31:0] sum_ba;
    t_class      cls;

    assign sum_ba    = r_b + r_a;
    assign addr_b    = r_b[AW-1:0];
    assign addr_d    = r_rdata[AW-1:0];
    assign addr_copy = sum_ba[AW-1:0];
    assign push_idx  = r_lcnt + 1'b1;
    assign div_trial = {r_rem, r_quo[31]} - {1'b0, r_b};

    always_comb begin
        cls = CL_SIMPLE;
        if (!r_halt) begin
            case (r_mode)
                OP_GET, OP_PUTI, OP_DECM, OP_INCM, OP_AT, OP_COPY: cls = CL_MEM1;
                OP_GETI:        cls = CL_MEM2;
                OP_DIV, OP_MOD: cls = CL_DIV;
                OP_RS:          cls = (r_lcnt != '0) ? CL_MEM1 : CL_SIMPLE;
                default:        cls = CL_SIMPLE;
            endcase
        end
    end

    assign o_stat.clear_last = (r_clr == {AW{1'b1}});
    assign o_stat.cls        = cls;
    assign o_stat.div_last   = (r_dcnt == 5'd31);
    assign o_stat.out_full   = r_ovalid;

    always_comb begin
        n_a = r_a; n_b = r_b; n_t = r_t; n_r = r_r;
        n_lcnt = r_lcnt; n_halt = r_halt;
        n_taken = r_taken; n_resume = r_resume;
        n_quo = r_quo; n_rem = r_rem; n_dcnt = r_dcnt;
        mem_we = 1'b0; mem_addr = addr_b; mem_wdata = r_a;
        stk_we = 1'b0;
        case (i_cmd.phase)
            P_CLEAR: begin
                mem_we = 1'b1; mem_addr = r_clr; mem_wdata = '0;
            end
            P_LATCH: begin
                n_taken = 1'b0; n_resume = '0;
            end
            P_EXEC: begin
                if (!r_halt) begin
                    case (r_mode)
                        OP_ADD:  n_a = r_a + r_b;
                        OP_SUB:  n_a = r_a - r_b;
                        OP_MUL:  n_a = r_a * r_b;
                        OP_DIV, OP_MOD: begin
                            n_quo = r_a; n_rem = '0; n_dcnt = '0;
                        end
                        OP_OR:   n_a = r_a | r_b;
                        OP_AND:  n_a = r_a & r_b;
                        OP_XOR:  n_a = r_a ^ r_b;
                        OP_SHL:  n_a = r_a << r_b[4:0];
                        OP_SHR:  n_a = r_a >> r_b[4:0];
                        OP_PUT:  mem_we = 1'b1;
                        OP_INC:  n_b = r_b + 32'd1;
                        OP_DEC:  n_b = r_b - 32'd1;
                        OP_IMM:  n_b = {1'b0, r_imm};
                        OP_FLIP: n_b = r_b ^ SIGN_BIT;
                        OP_SWAP: begin
                            n_b = r_a; n_a = r_b;
                        end
                        OP_TOB:  n_b = r_a;
                        OP_TOT:  n_t = r_a;
                        OP_TOR:  n_r = r_a;
                        OP_FROMB: n_a = r_b;
                        OP_FROMT: n_a = r_t;
                        OP_FROMR: n_a = r_r;
                        OP_MDM:  n_a = 32'(DATA_WORDS);
                        OP_LSA:  n_a = 32'(LINK_DEPTH) - 32'(r_lcnt);
                        OP_LSE:  n_a = 32'(r_lcnt);
                        OP_HALT: n_halt = 1'b1;
                        OP_JMPA: n_taken = (r_a == '0);
                        OP_JMPB: n_taken = (r_b == '0);
                        OP_JMPE: n_taken = (r_a == r_b);
                        OP_JMPN: n_taken = r_a[31];
                        OP_JMPS: n_taken = ((r_a & r_b) == r_b);
                        OP_JMPU: n_taken = ((r_a | r_b) == r_b);
                        OP_JUMP: n_taken = 1'b1;
                        OP_RPT: begin
                            if (r_r != '0) begin
                                n_r = r_r - 32'd1; n_taken = 1'b1;
                            end
                        end
                        OP_GO: begin
                            if (r_lcnt != LINK_TOP) begin
                                n_lcnt = push_idx; stk_we = 1'b1; n_taken = 1'b1;
                            end else begin
                                n_a = 32'd1; n_halt = 1'b1;
                            end
                        end
                        OP_RS: begin
                            // the pop itself completes in the next phase
                            if (r_lcnt == '0) begin
                                n_a = 32'd1; n_halt = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            P_MEM1: begin
                case (r_mode)
                    OP_GET:  n_a = r_rdata;
                    OP_GETI: mem_addr = addr_d;
                    OP_PUTI: begin
                        mem_we = 1'b1; mem_addr = addr_d;
                    end
                    OP_DECM: begin
                        mem_we = 1'b1; mem_wdata = r_rdata - 32'd1;
                    end
                    OP_INCM: begin
                        mem_we = 1'b1; mem_wdata = r_rdata + 32'd1;
                    end
                    OP_AT:   n_b = r_rdata;
                    OP_COPY: begin
                        mem_we = 1'b1; mem_addr = addr_copy; mem_wdata = r_rdata;
                    end
                    OP_RS: begin
                        n_resume = r_stk_q; n_lcnt = r_lcnt - 1'b1; n_taken = 1'b1;
                    end
                    default: ;
                endcase
            end
            P_MEM2: begin
                n_a = r_rdata;
            end
            P_DIV: begin
                // one restoring step per cycle
                if (!div_trial[32]) begin
                    n_rem = div_trial[31:0];
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = {r_rem[30:0], r_quo[31]};
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
            end
            P_FINISH: begin
                if (cls == CL_DIV) begin
                    if (r_mode == OP_DIV) n_a = (r_b == '0) ? 32'hffff_ffff : r_quo;
                    else                  n_a = (r_b == '0) ? r_a : r_rem;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_rdata <= mem[mem_addr];
        if (stk_we) stk[push_idx] <= r_ret;
        r_stk_q <= stk[r_lcnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0; r_b <= '0; r_t <= '0; r_r <= '0;
            r_lcnt <= '0; r_halt <= 1'b0;
            r_clr <= '0; r_dcnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_a <= n_a; r_b <= n_b; r_t <= n_t; r_r <= n_r;
            r_lcnt <= n_lcnt; r_halt <= n_halt;
            r_dcnt <= n_dcnt;
            if (i_cmd.phase == P_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cmd.phase == P_FINISH) r_ovalid <= 1'b1;
            else if (i_ready)            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_taken <= n_taken; r_resume <= n_resume;
        r_quo <= n_quo; r_rem <= n_rem;
        if (i_cmd.phase == P_LATCH) begin
            r_mode <= t_mode'(i_mode);
            r_imm  <= i_immediate;
            r_ret  <= i_return_address & RET_MASK;
        end
        if (i_cmd.phase == P_FINISH) begin
            r_otaken  <= n_taken;
            r_oresume <= n_resume;
            r_ohalt   <= n_halt;
            r_oacc    <= n_a;
        end
    end

    assign o_valid             = r_ovalid;
    assign o_branch_taken      = r_otaken;
    assign o_resume_address    = r_oresume;
    assign o_halted            = r_ohalt;
    assign o_exit_code         = r_ohalt ? r_oacc[7:0] : 8'd0;
    assign o_accumulator_value = r_oacc;

endmodule

// ----- hw/rtl/accumulator_machine_execute_top.sv -----
// Accumulator machine execute unit, top level.
// Input channel (i_valid / o_ready) takes one instruction request: mode,
// immediate and return address. Output channel (o_valid / i_ready) returns
// one result per request: branch taken, resume address, halted, exit code
// and the accumulator after the instruction.
// One request at a time. Register, jump, put and go requests pass from
// acceptance through the execute state to the result; get, put indirect,
// decrement, increment, at, copy and resume requests add a MEM1 state,
// indirect loads MEM1 and MEM2, division and modulo use a radix-2 divider (one
// quotient bit per cycle). The single-port data memory needs the MEM states.
// o_ready rises with the result. After reset, o_ready stays low while the
// DATA_WORDS words (65536 by default) are swept to zero, one word per cycle.
// A finished result sits in an output register; the next request is taken
// while it waits, but its own result holds until the receiver takes the
// previous one.
// depends on ame_pkg, ame_ctrl, ame_dpath
module accumulator_machine_execute_top import ame_pkg::*; #(
    parameter int DATA_WORDS     = 65536,
    parameter int LINK_DEPTH     = 256,
    parameter int PROG_ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_mode,
    input  logic [30:0] i_immediate,
    input  logic [15:0] i_return_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_branch_taken,
    output logic [15:0] o_resume_address,
    output logic        o_halted,
    output logic [7:0]  o_exit_code,
    output logic [31:0] o_accumulator_value
);

    t_cmd  cmd;
    t_stat stat;

    ame_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    ame_dpath #(
        .DATA_WORDS     (DATA_WORDS),
        .LINK_DEPTH     (LINK_DEPTH),
        .PROG_ADDR_BITS (PROG_ADDR_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_mode              (i_mode),
        .i_immediate         (i_immediate),
        .i_return_address    (i_return_address),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_branch_taken      (o_branch_taken),
        .o_resume_address    (o_resume_address),
        .o_halted            (o_halted),
        .o_exit_code         (o_exit_code),
        .o_accumulator_value (o_accumulator_value)
    );

endmodule

// ----- hw/rtl/ame_chk.sv -----
// port-level checks of the accumulator machine execute unit
// depends on accumulator_machine_execute_top_macros.svh
`include "accumulator_machine_execute_top_macros.svh"

module ame_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [5:0]  i_mode,
    input logic [30:0] i_immediate,
    input logic [15:0] i_return_address,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_branch_taken,
    input logic [15:0] o_resume_address,
    input logic        o_halted,
    input logic [7:0]  o_exit_code,
    input logic [31:0] o_accumulator_value
);

    `AME_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `AME_ASSERT_SAME(a_exit_zero, i_clk, i_rst_n, o_valid && !o_halted, o_exit_code == 8'd0)
    `AME_ASSERT_SAME(a_exit_byte, i_clk, i_rst_n, o_valid && o_halted, o_exit_code == o_accumulator_value[7:0])
    `AME_ASSERT_SAME(a_halt_no_br, i_clk, i_rst_n, o_valid && o_halted, !o_branch_taken)
    `AME_ASSERT_SAME(a_resume_br, i_clk, i_rst_n, o_valid && (o_resume_address != 16'd0), o_branch_taken)

endmodule

bind accumulator_machine_execute_top ame_chk u_ame_chk (.*);

// ----- tb/sv/tb_accumulator_machine_execute_top.sv -----
`timescale 1ns / 100ps
// testbench of the accumulator machine execute unit: a directed table, an op sweep,
// then random instruction streams, checked against a behavioral predictor of the machine
// depends on ame_pkg and accumulator_machine_execute_top
module tb_accumulator_machine_execute_top;
    import ame_pkg::*;

    localparam int DATA_WORDS     = 65536;
    localparam int LINK_DEPTH     = 256;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int N_RANDOM       = 180;

    typedef struct packed {
        logic        branch_taken;
        logic [15:0] resume_address;
        logic        halted;
        logic [7:0]  exit_code;
        logic [31:0] accumulator_value;
    } t_result;

    typedef struct {
        logic [5:0]  mode;
        logic [30:0] immediate;
        logic [15:0] return_address;
        logic        fixed;
        t_result     result;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [5:0]  i_mode;
    logic [30:0] i_immediate;
    logic [15:0] i_return_address;
    logic        o_valid;
    logic        i_ready;
    logic        o_branch_taken;
    logic [15:0] o_resume_address;
    logic        o_halted;
    logic [7:0]  o_exit_code;
    logic [31:0] o_accumulator_value;

    accumulator_machine_execute_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_mode              (i_mode),
        .i_immediate         (i_immediate),
        .i_return_address    (i_return_address),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_branch_taken      (o_branch_taken),
        .o_resume_address    (o_resume_address),
        .o_halted            (o_halted),
        .o_exit_code         (o_exit_code),
        .o_accumulator_value (o_accumulator_value)
    );

    // machine state as the predictor sees it
    logic [31:0] acc_q, opnd_q, temp_q, rep_q;
    int unsigned link_fill;
    logic [15:0] link_mem [LINK_DEPTH];
    logic [31:0] data_mem [DATA_WORDS];
    logic        is_halted;

    t_result     expected_results[$];
    t_result     fixed_results[$];
    logic        fixed_flags[$];
    int          n_errors;
    int          n_idle_cycles;
    bit          stall_free;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] waddr(logic [31:0] w);
        return w[15:0];
    endfunction

    task automatic machine_reset();
        acc_q = '0; opnd_q = '0; temp_q = '0; rep_q = '0;
        link_fill = 0; is_halted = 1'b0;
        foreach (link_mem[k]) link_mem[k] = '0;
        foreach (data_mem[k]) data_mem[k] = '0;
    endtask

    function automatic t_result execute_instruction(logic [5:0] mode, logic [30:0] imm,
                                                    logic [15:0] ret);
        t_result r;
        logic [31:0] a, b;
        a = acc_q; b = opnd_q;
        r = '0;
        if (!is_halted) begin
            case (mode)
                OP_ADD:   acc_q = a + b;
                OP_SUB:   acc_q = a - b;
                OP_MUL:   acc_q = a * b;
                OP_DIV:   acc_q = (b != 0) ? a / b : 32'hffff_ffff;
                OP_MOD:   acc_q = (b != 0) ? a % b : a;
                OP_OR:    acc_q = a | b;
                OP_AND:   acc_q = a & b;
                OP_XOR:   acc_q = a ^ b;
                OP_SHL:   acc_q = a << b[4:0];
                OP_SHR:   acc_q = a >> b[4:0];
                OP_GET:   acc_q = data_mem[waddr(b)];
                OP_PUT:   data_mem[waddr(b)] = a;
                OP_GETI:  acc_q = data_mem[waddr(data_mem[waddr(b)])];
                OP_PUTI:  data_mem[waddr(data_mem[waddr(b)])] = a;
                OP_DECM:  data_mem[waddr(b)] = data_mem[waddr(b)] - 1;
                OP_INCM:  data_mem[waddr(b)] = data_mem[waddr(b)] + 1;
                OP_AT:    opnd_q = data_mem[waddr(b)];
                OP_COPY:  data_mem[waddr(b + a)] = data_mem[waddr(b)];
                OP_INC:   opnd_q = b + 1;
                OP_DEC:   opnd_q = b - 1;
                OP_IMM:   opnd_q = {1'b0, imm};
                OP_FLIP:  opnd_q = b ^ SIGN_BIT;
                OP_SWAP:  begin opnd_q = a; acc_q = b; end
                OP_TOB:   opnd_q = a;
                OP_TOT:   temp_q = a;
                OP_TOR:   rep_q = a;
                OP_FROMB: acc_q = b;
                OP_FROMT: acc_q = temp_q;
                OP_FROMR: acc_q = rep_q;
                OP_MDM:   acc_q = DATA_WORDS;
                OP_LSA:   acc_q = LINK_DEPTH - link_fill;
                OP_LSE:   acc_q = link_fill;
                OP_HALT:  is_halted = 1'b1;
                OP_JMPA:  r.branch_taken = (a == 0);
                OP_JMPB:  r.branch_taken = (b == 0);
                OP_JMPE:  r.branch_taken = (a == b);
                OP_JMPN:  r.branch_taken = a[31];
                OP_JMPS:  r.branch_taken = ((a & b) == b);
                OP_JMPU:  r.branch_taken = ((a | b) == b);
                OP_JUMP:  r.branch_taken = 1'b1;
                OP_RPT: begin
                    if (rep_q != 0) begin
                        rep_q = rep_q - 1;
                        r.branch_taken = 1'b1;
                    end
                end
                OP_GO: begin
                    if (link_fill < LINK_DEPTH - 1) begin
                        link_fill++;
                        link_mem[link_fill] = ret;
                        r.branch_taken = 1'b1;
                    end else begin
                        acc_q = 1; is_halted = 1'b1;
                    end
                end
                OP_RS: begin
                    if (link_fill > 0) begin
                        r.resume_address = link_mem[link_fill];
                        link_fill--;
                        r.branch_taken = 1'b1;
                    end else begin
                        acc_q = 1; is_halted = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.halted = is_halted;
        r.exit_code = is_halted ? acc_q[7:0] : 8'd0;
        r.accumulator_value = acc_q;
        return r;
    endfunction

    function automatic bit idle_now();
        return !stall_free && ($urandom_range(99) < 36);
    endfunction

    // one request: drive at the falling edge, hold until accepted
    task automatic issue_request(logic [5:0] mode, logic [30:0] imm, logic [15:0] ret,
                                 logic fixed, t_result fixed_res);
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_immediate <= imm;
        i_return_address <= ret;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(execute_instruction(mode, imm, ret));
        fixed_flags.push_back(fixed);
        fixed_results.push_back(fixed_res);
        @(negedge i_clk);
    endtask

    // receiver side
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= !idle_now();
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        logic fx;
        t_result fres;
        if (i_rst_n && (i_valid && o_ready || o_valid && i_ready))
            n_idle_cycles <= 0;
        else
            n_idle_cycles <= n_idle_cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_branch_taken, o_resume_address, o_halted, o_exit_code,
                   o_accumulator_value};
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                fx = fixed_flags.pop_front();
                fres = fixed_results.pop_front();
                if (fx && fres != want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("table row disagrees with predictor: %h vs %h", fres, want);
                end
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: taken %b/%b resume %h/%h halted %b/%b exit %h/%h acc %h/%h",
                                 want.branch_taken, got.branch_taken,
                                 want.resume_address, got.resume_address,
                                 want.halted, got.halted, want.exit_code, got.exit_code,
                                 want.accumulator_value, got.accumulator_value);
                end
            end
        end
    end

    // the sweep after reset keeps o_ready low while the data memory is cleared
    initial begin
        @(posedge i_clk);
        while (n_idle_cycles < WATCHDOG_LIMIT || !i_rst_n) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    t_row dir_table[$];

    task automatic add_row(logic [5:0] m, logic [30:0] imm, logic [15:0] ret,
                           logic fx = 1'b0, t_result res = '0);
        t_row row;
        row.mode = m; row.immediate = imm; row.return_address = ret;
        row.fixed = fx; row.result = res;
        dir_table.push_back(row);
    endtask

    // one random instruction, biased to small addresses and valid stack use
    task automatic random_request();
        logic [5:0]  m;
        logic [30:0] imm;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 4) m = 6'($urandom_range(63, 44));
        else begin
            m = 6'($urandom_range(43, 0));
            if (m == OP_HALT) m = OP_NOP;
            // a pop on the empty link stack would halt the machine for good
            if (m == OP_RS && link_fill == 0) m = OP_GO;
        end
        case ($urandom_range(3))
            0: imm = 31'($urandom_range(15));
            1: imm = 31'($urandom_range(255));
            2: imm = 31'(32'h7fff_ffff - $urandom_range(3));
            default: imm = 31'($urandom);
        endcase
        issue_request(m, imm, 16'($urandom), 1'b0, '0);
    endtask

    initial begin
        t_result r0;
        n_errors = 0;
        n_idle_cycles = 0;
        stall_free = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = OP_NOP;
        i_immediate = '0;
        i_return_address = '0;
        machine_reset();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        r0 = '0;
        add_row(OP_NOP, '0, '0, 1'b1, r0);
        add_row(OP_DIV, '0, '0, 1'b1, '{1'b0, 16'd0, 1'b0, 8'd0, 32'hffff_ffff});
        add_row(OP_MOD, '0, '0, 1'b1, '{1'b0, 16'd0, 1'b0, 8'd0, 32'hffff_ffff});
        add_row(OP_MDM, '0, '0, 1'b1, '{1'b0, 16'd0, 1'b0, 8'd0, 32'd65536});
        add_row(OP_IMM, 31'h7fff_ffff, '0);
        add_row(OP_FLIP, '0, '0);
        add_row(OP_MUL, '0, '0);
        add_row(OP_SHL, '0, '0);
        add_row(OP_SHR, '0, '0);
        add_row(OP_PUT, '0, '0);
        add_row(OP_GETI, '0, '0);
        add_row(OP_INCM, '0, '0);
        add_row(OP_COPY, '0, '0);
        add_row(OP_GO, '0, 16'hffff);
        add_row(OP_GO, '0, 16'h0000);
        add_row(OP_RS, '0, '0);
        add_row(OP_RS, '0, '0);
        add_row(OP_JMPN, '0, '0);
        add_row(OP_TOR, '0, '0);
        add_row(OP_RPT, '0, '0);
        add_row(6'd63, '0, '0);
        for (int k = 0; k < dir_table.size(); k++)
            issue_request(dir_table[k].mode, dir_table[k].immediate,
                          dir_table[k].return_address, dir_table[k].fixed,
                          dir_table[k].result);

        // sweep every operation except halt once
        for (int m = 0; m < 44; m++)
            if (m != OP_HALT)
                issue_request(6'(m), 31'($urandom), 16'($urandom), 1'b0, '0);

        for (int k = 0; k < N_RANDOM; k++) begin
            stall_free = (k >= 40 && k < 100);
            if (k == 120) begin
                // fill the link stack to the overflow point, then keep going halted
                while (link_fill < LINK_DEPTH - 1 && !is_halted)
                    issue_request(OP_GO, '0, 16'($urandom), 1'b0, '0);
                issue_request(OP_GO, '0, 16'($urandom), 1'b0, '0);
            end
            random_request();
        end
        if (!is_halted) issue_request(OP_HALT, '0, '0, 1'b0, '0);
        issue_request(OP_ADD, '0, '0, 1'b0, '0);
        issue_request(OP_GO, '0, '1, 1'b0, '0);
        i_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ame_pkg.sv
hw/rtl/ame_ctrl.sv
hw/rtl/ame_dpath.sv
hw/rtl/accumulator_machine_execute_top.sv
hw/rtl/ame_chk.sv
tb/sv/tb_accumulator_machine_execute_top.sv
